@@ rtl/i2cdw_pkg.sv @@
// Package for the I2C display write master: payload structs, control bytes,
// request codes, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package i2cdw_pkg;

  // Request codes carried in the mode field.
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_COMMAND = 2'd1;
  localparam logic [1:0] MODE_DATA    = 2'd2;

  // Control bytes sent after the device address.
  localparam logic [7:0] CTRL_COMMAND = 8'h00;
  localparam logic [7:0] CTRL_DATA    = 8'h40;

  // Configuration register map.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_WAIT_LIMIT = 1'd1;

  localparam logic [7:0] ADDR_RESET = 8'h78;
  localparam logic [7:0] WAIT_RESET = 8'd250;

  // Byte position within a transaction.
  localparam logic [1:0] STAGE_ADDRESS = 2'd0;
  localparam logic [1:0] STAGE_CONTROL = 2'd1;
  localparam logic [1:0] STAGE_PAYLOAD = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       last;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic sda_released;
    logic request_taken;
    logic busy_res;
    logic ack_error;
  } out_item_t;

endpackage

@@ rtl/i2cdw_channels.sv @@
// Valid/ready channel interfaces for the I2C display write master.
// Depends on i2cdw_pkg for the payload structs.
`timescale 1ns / 1ps

interface i2cdw_in_if;
  import i2cdw_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface i2cdw_out_if;
  import i2cdw_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/i2c_display_write_master_core.sv @@
// Top level of the I2C display write master: bus sequencer and result register.
// Depends on i2cdw_pkg and the channel interfaces in i2cdw_channels.sv.
//
//   channel   direction  handshake          payload
//   in_ch     sink       valid / ready      mode, data_byte, last, sda_sample
//   out_ch    source     valid / ready      scl_level, sda_level, sda_released,
//                                           request_taken, busy_res, ack_error
//   cfg       write      cfg_we             cfg_index, cfg_data
//
// Each accepted transaction is one bus tick and yields one registered result.
// A new tick is accepted every cycle; the result register empties and refills
// in the same cycle, so in_ch.ready only drops while a result waits on out_ch.
// Reset puts the sequencer in idle and restores the register reset values.
`timescale 1ns / 1ps

module i2c_display_write_master_core (
  input  logic                                 clk,
  input  logic                                 rst,
  i2cdw_in_if.sink                             in_ch,
  i2cdw_out_if.source                          out_ch,
  input  logic                                 cfg_we,
  input  logic [i2cdw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [i2cdw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import i2cdw_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_BIT_LOW, PH_BIT_HIGH,
    PH_ACK_LOW, PH_ACK_HIGH, PH_WAIT_DATA, PH_STOP_A, PH_STOP_B, PH_STOP_C
  } phase_t;

  logic [7:0] device_address;
  logic [7:0] ack_wait_limit;

  phase_t     phase, phase_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] bit_index, bit_index_next;
  logic [1:0] byte_stage, byte_stage_next;
  logic [7:0] wait_count, wait_count_next;
  logic       is_data_run, is_data_run_next;
  logic [7:0] held_payload, held_payload_next;
  logic       run_ending, run_ending_next;

  logic       out_valid;
  out_item_t  result, result_next;
  logic       accept;
  logic       bitv;

  assign in_ch.ready    = !out_valid || out_ch.ready;
  assign accept         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = result;
  assign bitv           = shift_byte[7];

  always_comb begin
    phase_next        = phase;
    shift_byte_next   = shift_byte;
    bit_index_next    = bit_index;
    byte_stage_next   = byte_stage;
    wait_count_next   = wait_count;
    is_data_run_next  = is_data_run;
    held_payload_next = held_payload;
    run_ending_next   = run_ending;
    result_next       = '{scl_level: 1'b1, sda_level: 1'b1, sda_released: 1'b0,
                          request_taken: 1'b0, busy_res: 1'b1, ack_error: 1'b0};

    case (phase)
      PH_START_A: begin
        result_next.sda_level = 1'b0;
        phase_next = PH_START_B;
      end
      PH_START_B: begin
        result_next.scl_level = 1'b0;
        result_next.sda_level = 1'b0;
        byte_stage_next = STAGE_ADDRESS;
        shift_byte_next = device_address;
        bit_index_next  = 3'd0;
        phase_next      = PH_BIT_LOW;
      end
      PH_BIT_LOW: begin
        result_next.scl_level = 1'b0;
        result_next.sda_level = bitv;
        phase_next = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        result_next.sda_level = bitv;
        shift_byte_next = {shift_byte[6:0], 1'b0};
        if (bit_index == 3'd7) begin
          bit_index_next = 3'd0;
          phase_next     = PH_ACK_LOW;
        end else begin
          bit_index_next = bit_index + 3'd1;
          phase_next     = PH_BIT_LOW;
        end
      end
      PH_ACK_LOW: begin
        result_next.scl_level    = 1'b0;
        result_next.sda_released = 1'b1;
        wait_count_next = 8'd0;
        phase_next      = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        result_next.sda_released = 1'b1;
        if (in_ch.payload.sda_sample) begin
          // No acknowledge yet: count high samples until the limit runs out.
          if (wait_count >= ack_wait_limit) begin
            result_next.ack_error = 1'b1;
            wait_count_next = 8'd0;
            phase_next      = PH_STOP_A;
          end else begin
            wait_count_next = wait_count + 8'd1;
          end
        end else if (byte_stage == STAGE_ADDRESS) begin
          byte_stage_next = STAGE_CONTROL;
          shift_byte_next = is_data_run ? CTRL_DATA : CTRL_COMMAND;
          bit_index_next  = 3'd0;
          phase_next      = PH_BIT_LOW;
        end else if (byte_stage == STAGE_CONTROL) begin
          byte_stage_next = STAGE_PAYLOAD;
          shift_byte_next = held_payload;
          bit_index_next  = 3'd0;
          phase_next      = PH_BIT_LOW;
        end else if (run_ending) begin
          phase_next = PH_STOP_A;
        end else begin
          phase_next = PH_WAIT_DATA;
        end
      end
      PH_WAIT_DATA: begin
        result_next.scl_level = 1'b0;
        result_next.sda_level = 1'b0;
        if (in_ch.payload.mode == MODE_DATA) begin
          result_next.request_taken = 1'b1;
          held_payload_next = in_ch.payload.data_byte;
          run_ending_next   = in_ch.payload.last;
          shift_byte_next   = in_ch.payload.data_byte;
          bit_index_next    = 3'd0;
          phase_next        = PH_BIT_LOW;
        end
      end
      PH_STOP_A: begin
        result_next.scl_level = 1'b0;
        result_next.sda_level = 1'b0;
        phase_next = PH_STOP_B;
      end
      PH_STOP_B: begin
        result_next.sda_level = 1'b0;
        phase_next = PH_STOP_C;
      end
      PH_STOP_C: begin
        phase_next = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
        if (in_ch.payload.mode == MODE_COMMAND || in_ch.payload.mode == MODE_DATA) begin
          result_next.request_taken = 1'b1;
          is_data_run_next  = (in_ch.payload.mode == MODE_DATA);
          held_payload_next = in_ch.payload.data_byte;
          // A command is always a single byte.
          run_ending_next   = (in_ch.payload.mode == MODE_DATA) ? in_ch.payload.last : 1'b1;
          byte_stage_next   = STAGE_ADDRESS;
          phase_next        = PH_START_A;
        end else begin
          result_next.busy_res = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= ADDR_RESET;
      ack_wait_limit <= WAIT_RESET;
      phase          <= PH_IDLE;
      shift_byte     <= 8'd0;
      bit_index      <= 3'd0;
      byte_stage     <= STAGE_ADDRESS;
      wait_count     <= 8'd0;
      is_data_run    <= 1'b0;
      run_ending     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEVICE_ADDRESS: device_address <= cfg_data;
          REG_ACK_WAIT_LIMIT: ack_wait_limit <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        phase       <= phase_next;
        shift_byte  <= shift_byte_next;
        bit_index   <= bit_index_next;
        byte_stage  <= byte_stage_next;
        wait_count  <= wait_count_next;
        is_data_run <= is_data_run_next;
        run_ending  <= run_ending_next;
        out_valid   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_payload <= held_payload_next;
      result       <= result_next;
    end
  end

endmodule

@@ tb/tb_i2c_display_write_master_core.sv @@
// Self-checking testbench for the I2C display write master: drives bus ticks,
// predicts every tick's line levels and flags, and checks them as they arrive.
// Depends on i2cdw_pkg, the channel interfaces and the core top level.
`timescale 1ns / 1ps

module tb_i2c_display_write_master_core;
  import i2cdw_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int STALL_LIMIT = 400;

  typedef enum logic [3:0] {
    BUS_IDLE, BUS_START_A, BUS_START_B, BUS_BIT_LOW, BUS_BIT_HIGH,
    BUS_ACK_LOW, BUS_ACK_HIGH, BUS_WAIT_DATA, BUS_STOP_A, BUS_STOP_B, BUS_STOP_C
  } bus_phase_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  i2cdw_in_if in_ch ();
  i2cdw_out_if out_ch ();

  i2c_display_write_master_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predicted sequencer state and register copies.
  bus_phase_t bus_phase;
  logic [7:0] shift_reg;
  logic [2:0] bit_cnt;
  logic [1:0] byte_pos;
  logic [7:0] miss_cnt;
  logic       data_run;
  logic [7:0] payload_hold;
  logic       final_byte;
  logic [7:0] cfg_addr;
  logic [7:0] cfg_limit;

  out_item_t expected_levels[$];
  int fail_count = 0;
  int idle_cycles = 0;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic in_item_t tick_item(logic [1:0] m, logic [7:0] b, logic l, logic s);
    in_item_t it;
    it.mode = m;
    it.data_byte = b;
    it.last = l;
    it.sda_sample = s;
    return it;
  endfunction

  function void load_byte(logic [7:0] value);
    shift_reg = value;
    bit_cnt = 3'd0;
    bus_phase = BUS_BIT_LOW;
  endfunction

  // Advances the predicted sequencer by one tick and returns the expected result.
  function out_item_t bus_levels(in_item_t it);
    out_item_t r;
    logic bitv;
    r = '0;
    r.scl_level = 1'b1;
    r.sda_level = 1'b1;
    r.busy_res = 1'b1;
    bitv = shift_reg[7];
    case (bus_phase)
      BUS_START_A: begin
        r.sda_level = 1'b0;
        bus_phase = BUS_START_B;
      end
      BUS_START_B: begin
        r.scl_level = 1'b0;
        r.sda_level = 1'b0;
        byte_pos = STAGE_ADDRESS;
        load_byte(cfg_addr);
      end
      BUS_BIT_LOW: begin
        r.scl_level = 1'b0;
        r.sda_level = bitv;
        bus_phase = BUS_BIT_HIGH;
      end
      BUS_BIT_HIGH: begin
        r.sda_level = bitv;
        shift_reg = {shift_reg[6:0], 1'b0};
        if (bit_cnt == 3'd7) begin
          bit_cnt = 3'd0;
          bus_phase = BUS_ACK_LOW;
        end else begin
          bit_cnt = bit_cnt + 3'd1;
          bus_phase = BUS_BIT_LOW;
        end
      end
      BUS_ACK_LOW: begin
        r.scl_level = 1'b0;
        r.sda_released = 1'b1;
        miss_cnt = 8'd0;
        bus_phase = BUS_ACK_HIGH;
      end
      BUS_ACK_HIGH: begin
        r.sda_released = 1'b1;
        if (it.sda_sample) begin
          if (miss_cnt >= cfg_limit) begin
            r.ack_error = 1'b1;
            miss_cnt = 8'd0;
            bus_phase = BUS_STOP_A;
          end else begin
            miss_cnt = miss_cnt + 8'd1;
          end
        end else if (byte_pos == STAGE_ADDRESS) begin
          byte_pos = STAGE_CONTROL;
          load_byte(data_run ? CTRL_DATA : CTRL_COMMAND);
        end else if (byte_pos == STAGE_CONTROL) begin
          byte_pos = STAGE_PAYLOAD;
          load_byte(payload_hold);
        end else if (final_byte) begin
          bus_phase = BUS_STOP_A;
        end else begin
          bus_phase = BUS_WAIT_DATA;
        end
      end
      BUS_WAIT_DATA: begin
        r.scl_level = 1'b0;
        r.sda_level = 1'b0;
        if (it.mode == MODE_DATA) begin
          r.request_taken = 1'b1;
          payload_hold = it.data_byte;
          final_byte = it.last;
          load_byte(it.data_byte);
        end
      end
      BUS_STOP_A: begin
        r.scl_level = 1'b0;
        r.sda_level = 1'b0;
        bus_phase = BUS_STOP_B;
      end
      BUS_STOP_B: begin
        r.sda_level = 1'b0;
        bus_phase = BUS_STOP_C;
      end
      BUS_STOP_C: begin
        bus_phase = BUS_IDLE;
      end
      default: begin
        bus_phase = BUS_IDLE;
        if (it.mode == MODE_COMMAND || it.mode == MODE_DATA) begin
          r.request_taken = 1'b1;
          data_run = (it.mode == MODE_DATA);
          payload_hold = it.data_byte;
          final_byte = (it.mode == MODE_DATA) ? it.last : 1'b1;
          byte_pos = STAGE_ADDRESS;
          bus_phase = BUS_START_A;
        end else begin
          r.busy_res = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  // Valid stays high after a transaction so that back-to-back ticks need no
  // second assignment in the same time step; it is lowered only before a gap.
  task automatic send_tick(in_item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    expected_levels.push_back(bus_levels(it));
  endtask

  // Runs the bus with acknowledges until idle or waiting for the next data byte.
  // Each acknowledge sees the given number of high samples first.
  task automatic advance_bus(logic [1:0] filler_mode, int misses);
    logic s;
    while (!(bus_phase inside {BUS_IDLE, BUS_WAIT_DATA})) begin
      s = (bus_phase == BUS_ACK_HIGH && miss_cnt < misses) ? 1'b1 : 1'b0;
      send_tick(tick_item(filler_mode, 8'($urandom), 1'($urandom), s));
    end
  endtask

  // Brings the bus back to idle and waits until every result has been checked.
  task automatic settle_bus();
    while (bus_phase != BUS_IDLE) begin
      if (bus_phase == BUS_WAIT_DATA)
        send_tick(tick_item(MODE_DATA, 8'($urandom), 1'b1, 1'b0));
      else
        send_tick(tick_item(MODE_TICK, 8'($urandom), 1'($urandom), 1'b0));
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_DEVICE_ADDRESS)
      cfg_addr = value;
    else
      cfg_limit = value;
  endtask

  task automatic apply_settings(logic [7:0] addr, logic [7:0] limit);
    settle_bus();
    write_register(REG_DEVICE_ADDRESS, addr);
    write_register(REG_ACK_WAIT_LIMIT, limit);
  endtask

  // An idle tick, the spare mode code, and a command with its last flag set,
  // while requests made during the transaction are dropped.
  task automatic test_request_modes();
    send_tick(tick_item(MODE_TICK, 8'h00, 1'b0, 1'b0));
    send_tick(tick_item(MODE_SPARE, 8'hFF, 1'b1, 1'b1));
    send_tick(tick_item(MODE_COMMAND, 8'hFF, 1'b1, 1'b0));
    advance_bus(MODE_DATA, 0);
  endtask

  // A data run of three bytes, with stray requests while the next byte is awaited.
  task automatic test_data_run();
    send_tick(tick_item(MODE_DATA, 8'h00, 1'b0, 1'b0));
    advance_bus(MODE_COMMAND, 0);
    send_tick(tick_item(MODE_COMMAND, 8'h12, 1'b1, 1'b1));
    send_tick(tick_item(MODE_TICK, 8'h34, 1'b1, 1'b0));
    send_tick(tick_item(MODE_SPARE, 8'h56, 1'b0, 1'b1));
    send_tick(tick_item(MODE_DATA, 8'hFF, 1'b0, 1'b1));
    advance_bus(MODE_TICK, 1);
    send_tick(tick_item(MODE_DATA, 8'hA5, 1'b1, 1'b0));
    advance_bus(MODE_SPARE, 0);
  endtask

  // With a wait limit of one: a late acknowledge just inside the limit,
  // then one that never comes and abandons the transaction.
  task automatic test_ack_timeout();
    apply_settings(8'h00, 8'd1);
    send_tick(tick_item(MODE_COMMAND, 8'h3C, 1'b0, 1'b0));
    advance_bus(MODE_TICK, 1);
    send_tick(tick_item(MODE_DATA, 8'h81, 1'b1, 1'b1));
    advance_bus(MODE_COMMAND, 2);
  endtask

  // Mostly well-formed requests with random payloads and acknowledges,
  // mixed with requests at the wrong time and spare mode codes.
  task automatic test_random_traffic(int n_ticks);
    in_item_t it;
    for (int k = 0; k < n_ticks; k++) begin
      if (k % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      it = tick_item(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      case (bus_phase)
        BUS_IDLE: begin
          if ($urandom_range(0, 9) < 7)
            it.mode = $urandom_range(0, 1) ? MODE_DATA : MODE_COMMAND;
          else
            it.mode = $urandom_range(0, 1) ? MODE_SPARE : MODE_TICK;
        end
        BUS_WAIT_DATA: begin
          if ($urandom_range(0, 3) != 0) it.mode = MODE_DATA;
          it.last = ($urandom_range(0, 2) == 0);
        end
        BUS_ACK_HIGH: it.sda_sample = ($urandom_range(0, 3) == 0);
        default: ;
      endcase
      send_tick(it);
    end
    calm = 1'b0;
  endtask

  task automatic test_random_settings();
    apply_settings(8'h00, 8'd1);
    test_random_traffic(60);
    apply_settings(8'hFF, 8'd255);
    test_random_traffic(60);
    apply_settings(8'($urandom), 8'($urandom_range(1, 3)));
    test_random_traffic(60);
    apply_settings(ADDR_RESET, WAIT_RESET);
    test_random_traffic(60);
  endtask

  // Result side: random stalls, then each result is checked against the oldest
  // prediction field by field.
  initial begin : result_check
    string names[6];
    out_item_t want;
    out_item_t got;
    int gap;
    names = '{"scl_level", "sda_level", "sda_released", "request_taken", "busy_res",
              "ack_error"};
    out_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = out_ch.payload;
      if (expected_levels.size() == 0) begin
        $display("%0t: result with no tick waiting, actual %p", $time, got);
        fail_count++;
      end else begin
        want = expected_levels.pop_front();
        for (int b = 0; b < 6; b++) begin
          if (want[5-b] !== got[5-b]) begin
            $display("%0t: %s expected %b actual %b", $time, names[b], want[5-b], got[5-b]);
            fail_count++;
          end
        end
      end
    end
  end

  // Ends the run if neither channel completes a transaction for too long.
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    calm = 1'b0;
    bus_phase = BUS_IDLE;
    shift_reg = 8'h00;
    bit_cnt = 3'd0;
    byte_pos = STAGE_ADDRESS;
    miss_cnt = 8'd0;
    data_run = 1'b0;
    payload_hold = 8'h00;
    final_byte = 1'b0;
    cfg_addr = ADDR_RESET;
    cfg_limit = WAIT_RESET;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_DEVICE_ADDRESS;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_request_modes();
    test_data_run();
    test_ack_timeout();
    test_random_settings();

    settle_bus();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
